### rtl/bsc_pkg.sv
// Shared constants, codes and controller/datapath interface types of the safety checker
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int MAX_PROCESSES = 8;
	localparam int MAX_RESOURCES = 8;
	localparam int AMOUNT_BITS   = 8;

	localparam int PB = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int RB = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int PCB = $clog2(MAX_PROCESSES + 1);
	localparam int RCB = $clog2(MAX_RESOURCES + 1);
	localparam int WB = AMOUNT_BITS + $clog2(MAX_PROCESSES + 1);
	localparam int STORE_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam logic [1:0] KIND_AVAIL = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_CLAIM = 2'd2;
	localparam logic [1:0] KIND_RUN   = 2'd3;

	localparam logic REG_NUM_PROCESSES = 1'b0;
	localparam logic REG_NUM_RESOURCES = 1'b1;

	typedef struct packed {
		logic           load;
		logic           start;
		logic           init_work;
		logic           add_work;
		logic           finish;
		logic           verdict;
		logic           safe;
		logic [PCB-1:0] count;
		logic [PB-1:0]  p;
		logic [RB-1:0]  j;
	} bsc_cmd_t;

	typedef struct packed {
		logic marked;
		logic short_fall;
		logic out_free;
	} bsc_stat_t;

endpackage

### rtl/bsc_ctrl.sv
// Sequencing state machine of the safety checker: scan passes, resource walks, result issue
`timescale 1ns / 1ps
module bsc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_accept,
	input  logic [1:0]                  kind,
	input  logic [bsc_pkg::PCB-1:0]     np,
	input  logic [bsc_pkg::RCB-1:0]     nr,
	input  bsc_pkg::bsc_stat_t          stat,
	output bsc_pkg::bsc_cmd_t           cmd,
	output logic                        idle
);
	import bsc_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INIT    = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_CHK_RD  = 4'd3;
	localparam logic [3:0] S_CHK_CMP = 4'd4;
	localparam logic [3:0] S_ADD_RD  = 4'd5;
	localparam logic [3:0] S_ADD_WR  = 4'd6;
	localparam logic [3:0] S_EMIT    = 4'd7;
	localparam logic [3:0] S_NEXT    = 4'd8;
	localparam logic [3:0] S_VERDICT = 4'd9;

	logic [3:0]     state_q, state_d;
	logic [PB-1:0]  p_q, p_d;
	logic [RB-1:0]  j_q, j_d;
	logic [PCB-1:0] count_q, count_d;
	logic           progress_q, progress_d;
	logic           j_last, p_last;

	assign j_last = (RCB'(j_q) == nr - RCB'(1));
	assign p_last = (PCB'(p_q) == np - PCB'(1));
	assign idle   = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		p_d        = p_q;
		j_d        = j_q;
		count_d    = count_q;
		progress_d = progress_q;
		cmd        = '0;
		cmd.p      = p_q;
		cmd.j      = j_q;
		cmd.count  = count_q;
		cmd.safe   = (count_q == np);
		unique case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					if (kind == KIND_RUN) begin
						cmd.start = 1'b1;
						count_d   = '0;
						j_d       = '0;
						state_d   = S_INIT;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_INIT: begin
				cmd.init_work = 1'b1;
				if (j_last) begin
					p_d        = '0;
					progress_d = 1'b0;
					state_d    = S_SCAN;
				end else begin
					j_d = j_q + RB'(1);
				end
			end
			S_SCAN: begin
				j_d = '0;
				if (stat.marked) begin
					state_d = S_NEXT;
				end else begin
					state_d = S_CHK_RD;
				end
			end
			S_CHK_RD: begin
				state_d = S_CHK_CMP;
			end
			S_CHK_CMP: begin
				if (stat.short_fall) begin
					state_d = S_NEXT;
				end else if (j_last) begin
					j_d     = '0;
					state_d = S_ADD_RD;
				end else begin
					j_d     = j_q + RB'(1);
					state_d = S_CHK_RD;
				end
			end
			S_ADD_RD: begin
				state_d = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.add_work = 1'b1;
				if (j_last) begin
					state_d = S_EMIT;
				end else begin
					j_d     = j_q + RB'(1);
					state_d = S_ADD_RD;
				end
			end
			S_EMIT: begin
				cmd.count = count_q + PCB'(1);
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					count_d    = count_q + PCB'(1);
					progress_d = 1'b1;
					state_d    = S_NEXT;
				end
			end
			S_NEXT: begin
				if (p_last) begin
					p_d = '0;
					if (progress_q) begin
						progress_d = 1'b0;
						state_d    = S_SCAN;
					end else begin
						state_d = S_VERDICT;
					end
				end else begin
					p_d     = p_q + PB'(1);
					state_d = S_SCAN;
				end
			end
			S_VERDICT: begin
				if (stat.out_free) begin
					cmd.verdict = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			p_q        <= '0;
			j_q        <= '0;
			count_q    <= '0;
			progress_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			p_q        <= p_d;
			j_q        <= j_d;
			count_q    <= count_d;
			progress_q <= progress_d;
		end
	end

endmodule

### rtl/bsc_datapath.sv
// Stores, work vector, finished marks, need comparison and result register
`timescale 1ns / 1ps
module bsc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  bsc_pkg::bsc_cmd_t  cmd,
	output bsc_pkg::bsc_stat_t stat,
	input  logic [1:0]         kind,
	input  logic [2:0]         process_index,
	input  logic [2:0]         resource_index,
	input  logic [7:0]         amount,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         finished_process,
	output logic               is_verdict,
	output logic               safe,
	output logic [3:0]         finished_count,
	output logic               last
);
	import bsc_pkg::*;

	logic [AMOUNT_BITS-1:0] avail_mem [MAX_RESOURCES];
	logic [AMOUNT_BITS-1:0] alloc_mem [STORE_DEPTH];
	logic [AMOUNT_BITS-1:0] claim_mem [STORE_DEPTH];
	logic [AMOUNT_BITS-1:0] alloc_rd_q, claim_rd_q;
	logic [WB-1:0]          work_q [MAX_RESOURCES];
	logic [MAX_PROCESSES-1:0] marks_q;

	logic [AMOUNT_BITS-1:0] wdata;
	logic [AW-1:0]          waddr, raddr;
	logic                   pi_ok, ri_ok;
	logic [WB:0]            claim_x, held_x;

	assign wdata = AMOUNT_BITS'(amount);
	assign pi_ok = (int'(process_index) < MAX_PROCESSES);
	assign ri_ok = (int'(resource_index) < MAX_RESOURCES);
	assign waddr = AW'(AW'(process_index) * AW'(MAX_RESOURCES) + AW'(resource_index));
	assign raddr = AW'(AW'(cmd.p) * AW'(MAX_RESOURCES) + AW'(cmd.j));

	always_ff @(posedge clk) begin
		if (cmd.load && ri_ok && kind == KIND_AVAIL) begin
			avail_mem[RB'(resource_index)] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && pi_ok && ri_ok && kind == KIND_ALLOC) begin
			alloc_mem[waddr] <= wdata;
		end
		alloc_rd_q <= alloc_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && pi_ok && ri_ok && kind == KIND_CLAIM) begin
			claim_mem[waddr] <= wdata;
		end
		claim_rd_q <= claim_mem[raddr];
	end

	// need exceeds work exactly when claim exceeds work plus allocation
	assign claim_x = (WB + 1)'(claim_rd_q);
	assign held_x  = (WB + 1)'(work_q[cmd.j]) + (WB + 1)'(alloc_rd_q);

	assign stat.short_fall = (claim_x > held_x);
	assign stat.marked     = marks_q[cmd.p];
	assign stat.out_free   = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				work_q[i] <= '0;
			end
			marks_q <= '0;
		end else begin
			if (cmd.start) begin
				for (int i = 0; i < MAX_RESOURCES; i++) begin
					work_q[i] <= '0;
				end
				marks_q <= '0;
			end else if (cmd.init_work) begin
				work_q[cmd.j] <= WB'(avail_mem[cmd.j]);
			end else if (cmd.add_work) begin
				work_q[cmd.j] <= work_q[cmd.j] + WB'(alloc_rd_q);
			end
			if (cmd.finish) begin
				marks_q[cmd.p] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.finish || cmd.verdict) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			finished_process <= 3'(cmd.p);
			is_verdict       <= 1'b0;
			safe             <= 1'b0;
			finished_count   <= 4'(cmd.count);
			last             <= 1'b0;
		end else if (cmd.verdict) begin
			finished_process <= '0;
			is_verdict       <= 1'b1;
			safe             <= cmd.safe;
			finished_count   <= 4'(cmd.count);
			last             <= 1'b1;
		end
	end

endmodule

### rtl/bankers_safety_check.sv
// Banker's algorithm safety check: top level with register port, controller and datapath
// A load request leaves the checker idle; a run request holds the input stalled until its verdict.
// Run: set up work from availability; a process visit skips it if already finished, stops
// at the first resource that falls short, else adds its allocation and reports it; at most np + 1
// passes, then the verdict, each result held while the output stalls.
// Reset: counts return to 8, work and finished marks clear; stores hold nothing until written.
`timescale 1ns / 1ps
module bankers_safety_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  process_index,
	input  logic [2:0]  resource_index,
	input  logic [7:0]  amount,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  finished_process,
	output logic        is_verdict,
	output logic        safe,
	output logic [3:0]  finished_count,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsc_pkg::*;

	logic [3:0]     num_processes_q, num_resources_q;
	logic [PCB-1:0] np;
	logic [RCB-1:0] nr;
	logic           req_accept, idle;
	bsc_cmd_t       cmd;
	bsc_stat_t      stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_processes_q <= 4'd8;
			num_resources_q <= 4'd8;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_NUM_PROCESSES: num_processes_q <= pwdata[3:0];
				REG_NUM_RESOURCES: num_resources_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NUM_PROCESSES: prdata = {28'd0, num_processes_q};
			REG_NUM_RESOURCES: prdata = {28'd0, num_resources_q};
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		if (num_processes_q == 4'd0) begin
			np = PCB'(1);
		end else if (int'(num_processes_q) > MAX_PROCESSES) begin
			np = PCB'(MAX_PROCESSES);
		end else begin
			np = PCB'(num_processes_q);
		end
		if (num_resources_q == 4'd0) begin
			nr = RCB'(1);
		end else if (int'(num_resources_q) > MAX_RESOURCES) begin
			nr = RCB'(MAX_RESOURCES);
		end else begin
			nr = RCB'(num_resources_q);
		end
	end

	assign req_stall  = !idle;
	assign req_accept = req_valid && !req_stall;

	bsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_accept (req_accept),
		.kind       (kind),
		.np         (np),
		.nr         (nr),
		.stat       (stat),
		.cmd        (cmd),
		.idle       (idle)
	);

	bsc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.kind             (kind),
		.process_index    (process_index),
		.resource_index   (resource_index),
		.amount           (amount),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.finished_process (finished_process),
		.is_verdict       (is_verdict),
		.safe             (safe),
		.finished_count   (finished_count),
		.last             (last)
	);

endmodule

### bench/tb.sv
// Self-checking testbench for the safety checker: directed, clamp, backpressure, random phases
`timescale 1ns / 1ps
module tb;
	import bsc_pkg::*;

	typedef struct packed {
		logic [2:0] proc_id;
		logic       verdict;
		logic       safe_flag;
		logic [3:0] count;
		logic       is_last;
	} safety_result_t;

	localparam int IDLE_LIMIT     = 20000;
	localparam int PHASE_REQUESTS = 45;
	localparam int HOLD_CYCLES    = 600;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        req_valid      = 1'b0;
	logic        req_stall;
	logic [1:0]  kind           = KIND_AVAIL;
	logic [2:0]  process_index  = '0;
	logic [2:0]  resource_index = '0;
	logic [7:0]  amount         = '0;
	logic        res_valid;
	logic        res_stall      = 1'b0;
	logic [2:0]  finished_process;
	logic        is_verdict;
	logic        safe;
	logic [3:0]  finished_count;
	logic        last;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [2:0]  paddr          = '0;
	logic [31:0] pwdata         = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	logic [7:0] avail_q [MAX_RESOURCES];
	logic [7:0] alloc_q [MAX_PROCESSES][MAX_RESOURCES];
	logic [7:0] claim_q [MAX_PROCESSES][MAX_RESOURCES];
	bit         avail_set [MAX_RESOURCES];
	bit         alloc_set [MAX_PROCESSES][MAX_RESOURCES];
	bit         claim_set [MAX_PROCESSES][MAX_RESOURCES];
	logic [3:0] np_reg = 4'd8;
	logic [3:0] nr_reg = 4'd8;

	safety_result_t pending_results[$];
	int failures      = 0;
	int requests_sent = 0;
	int quiet_cycles  = 0;
	int tx_max        = 19;
	int rx_max        = 19;
	int rx_hold       = 0;

	always #5 clk = ~clk;

	bankers_safety_check u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.kind             (kind),
		.process_index    (process_index),
		.resource_index   (resource_index),
		.amount           (amount),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.finished_process (finished_process),
		.is_verdict       (is_verdict),
		.safe             (safe),
		.finished_count   (finished_count),
		.last             (last),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	function automatic int active_count(logic [3:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic void scan_for_safe_order();
		int np;
		int nr;
		int cnt;
		int need;
		bit progress;
		bit fits;
		logic [WB-1:0] work [MAX_RESOURCES];
		bit done [MAX_PROCESSES];
		np = active_count(np_reg, MAX_PROCESSES);
		nr = active_count(nr_reg, MAX_RESOURCES);
		cnt = 0;
		foreach (done[p]) done[p] = 1'b0;
		foreach (work[j]) work[j] = '0;
		for (int j = 0; j < nr; j++) work[j] = WB'(avail_q[j]);
		do begin
			progress = 1'b0;
			for (int p = 0; p < np; p++) begin
				if (done[p]) continue;
				fits = 1'b1;
				for (int j = 0; j < nr; j++) begin
					need = int'(claim_q[p][j]) - int'(alloc_q[p][j]);
					if (need > int'(work[j])) fits = 1'b0;
				end
				if (!fits) continue;
				for (int j = 0; j < nr; j++) work[j] = work[j] + WB'(alloc_q[p][j]);
				done[p] = 1'b1;
				cnt++;
				progress = 1'b1;
				pending_results.push_back('{proc_id: 3'(p), verdict: 1'b0, safe_flag: 1'b0,
					count: 4'(cnt), is_last: 1'b0});
			end
		end while (progress);
		pending_results.push_back('{proc_id: 3'd0, verdict: 1'b1, safe_flag: (cnt == np),
			count: 4'(cnt), is_last: 1'b1});
	endfunction

	function automatic void predict_request(logic [1:0] k, logic [2:0] p, logic [2:0] r,
			logic [7:0] a);
		case (k)
			KIND_AVAIL: begin
				avail_q[r] = a;
				avail_set[r] = 1'b1;
			end
			KIND_ALLOC: begin
				alloc_q[p][r] = a;
				alloc_set[p][r] = 1'b1;
			end
			KIND_CLAIM: begin
				claim_q[p][r] = a;
				claim_set[p][r] = 1'b1;
			end
			KIND_RUN: begin
				scan_for_safe_order();
			end
		endcase
	endfunction

	task automatic offer_request(logic [1:0] k, logic [2:0] p, logic [2:0] r, logic [7:0] a);
		int gap;
		gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid      <= 1'b1;
		kind           <= k;
		process_index  <= p;
		resource_index <= r;
		amount         <= a;
		do @(posedge clk); while (req_stall);
		predict_request(k, p, r, a);
		requests_sent++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [3:0] value);
		logic [31:0] word;
		word = $urandom();
		word[3:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (prdata !== {28'd0, value}) begin
			$error("prdata: expected %0d, got %0d", value, prdata);
			failures++;
		end
		if (idx == REG_NUM_PROCESSES) np_reg = value;
		else nr_reg = value;
	endtask

	task automatic configure(logic [3:0] np, logic [3:0] nr);
		settle();
		write_register(REG_NUM_PROCESSES, np);
		write_register(REG_NUM_RESOURCES, nr);
	endtask

	task automatic run_check();
		offer_request(KIND_RUN, 3'($urandom()), 3'($urandom()), 8'($urandom()));
	endtask

	task automatic rewrite_cell(int p, int j);
		logic [7:0] al;
		logic [7:0] cl;
		al = 8'($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) cl = 8'($urandom_range(0, al));
		else cl = al + 8'($urandom_range(0, 4));
		offer_request(KIND_ALLOC, 3'(p), 3'(j), al);
		offer_request(KIND_CLAIM, 3'(p), 3'(j), cl);
	endtask

	// fill every entry a run will read that has not been written yet
	task automatic ensure_loaded();
		int np;
		int nr;
		np = active_count(np_reg, MAX_PROCESSES);
		nr = active_count(nr_reg, MAX_RESOURCES);
		for (int j = 0; j < nr; j++)
			if (!avail_set[j]) offer_request(KIND_AVAIL, 3'($urandom()), 3'(j),
				8'($urandom_range(0, 6)));
		for (int p = 0; p < np; p++)
			for (int j = 0; j < nr; j++) begin
				if (!alloc_set[p][j]) offer_request(KIND_ALLOC, 3'(p), 3'(j),
					8'($urandom_range(0, 3)));
				if (!claim_set[p][j]) offer_request(KIND_CLAIM, 3'(p), 3'(j),
					alloc_q[p][j] + 8'($urandom_range(0, 3)));
			end
	endtask

	task automatic random_scenario();
		int np;
		int nr;
		np = active_count(np_reg, MAX_PROCESSES);
		nr = active_count(nr_reg, MAX_RESOURCES);
		ensure_loaded();
		if (np * nr <= 16) begin
			for (int j = 0; j < nr; j++)
				offer_request(KIND_AVAIL, 3'($urandom()), 3'(j), 8'($urandom_range(0, 8)));
			for (int p = 0; p < np; p++)
				for (int j = 0; j < nr; j++) rewrite_cell(p, j);
		end else begin
			repeat ($urandom_range(1, 6))
				rewrite_cell($urandom_range(0, np - 1), $urandom_range(0, nr - 1));
			if ($urandom_range(0, 1) == 0)
				offer_request(KIND_AVAIL, 3'($urandom()), 3'($urandom_range(0, nr - 1)),
					8'($urandom_range(0, 8)));
		end
		run_check();
	endtask

	task automatic random_noise();
		logic [7:0] a;
		a = ($urandom_range(0, 1) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 4));
		offer_request(2'($urandom_range(KIND_AVAIL, KIND_CLAIM)), 3'($urandom()),
			3'($urandom()), a);
	endtask

	task automatic test_single_cell();
		configure(4'd1, 4'd1);
		offer_request(KIND_AVAIL, 3'd0, 3'd0, 8'd0);
		offer_request(KIND_ALLOC, 3'd0, 3'd0, 8'd255);
		offer_request(KIND_CLAIM, 3'd0, 3'd0, 8'd0);
		run_check();
		offer_request(KIND_CLAIM, 3'd0, 3'd0, 8'd255);
		offer_request(KIND_ALLOC, 3'd0, 3'd0, 8'd0);
		run_check();
		offer_request(KIND_AVAIL, 3'd7, 3'd0, 8'd255);
		run_check();
		// rows and columns outside the active counts must not matter
		offer_request(KIND_AVAIL, 3'd0, 3'd7, 8'd255);
		offer_request(KIND_ALLOC, 3'd7, 3'd7, 8'd255);
		offer_request(KIND_CLAIM, 3'd7, 3'd7, 8'd0);
		run_check();
		offer_request(KIND_AVAIL, 3'd0, 3'd0, 8'd254);
		run_check();
	endtask

	task automatic test_register_clamps();
		configure(4'd0, 4'd0);
		run_check();
		configure(4'd15, 4'd9);
		ensure_loaded();
		run_check();
		configure(4'd8, 4'd8);
		run_check();
	endtask

	task automatic test_result_backpressure();
		configure(4'd8, 4'd2);
		ensure_loaded();
		tx_max  = 0;
		rx_hold = HOLD_CYCLES;
		repeat (6) run_check();
		settle();
		tx_max = 19;
	endtask

	task automatic test_random_phases();
		int np_list [5];
		int nr_list [5];
		int first;
		np_list = '{1, 8, 2, 8, 0};
		nr_list = '{8, 1, 3, 8, 0};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4) configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			else configure(4'(np_list[ph]), 4'(nr_list[ph]));
			tx_max = (ph % 3 == 1) ? 0 : 19;
			rx_max = (ph % 3 == 2) ? 0 : 19;
			first = requests_sent;
			while (requests_sent - first < PHASE_REQUESTS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: random_scenario();
					6, 7: random_noise();
					default: begin
						ensure_loaded();
						run_check();
					end
				endcase
				// drain every outstanding result now and then
				if ($urandom_range(0, 19) == 0) settle();
			end
		end
		tx_max = 19;
		rx_max = 19;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_cell();
		test_register_clamps();
		test_result_backpressure();
		test_random_phases();
		settle();
		repeat (50) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int wait_cycles;
		forever begin
			if (rx_hold > 0) begin
				res_stall <= 1'b1;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				wait_cycles = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
				if (wait_cycles > 0) begin
					res_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
				end
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	always @(posedge clk) begin : check_results
		safety_result_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing pending: finished_process %0d, is_verdict %0d",
						finished_process, is_verdict);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (finished_process !== want.proc_id) begin
						$error("finished_process: expected %0d, got %0d", want.proc_id,
							finished_process);
						failures++;
					end
					if (is_verdict !== want.verdict) begin
						$error("is_verdict: expected %0d, got %0d", want.verdict, is_verdict);
						failures++;
					end
					if (safe !== want.safe_flag) begin
						$error("safe: expected %0d, got %0d", want.safe_flag, safe);
						failures++;
					end
					if (finished_count !== want.count) begin
						$error("finished_count: expected %0d, got %0d", want.count,
							finished_count);
						failures++;
					end
					if (last !== want.is_last) begin
						$error("last: expected %0d, got %0d", want.is_last, last);
						failures++;
					end
				end
			end
			if ((req_valid && !req_stall) || (res_valid && !res_stall) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule

### filelist.f
rtl/bsc_pkg.sv
rtl/bsc_ctrl.sv
rtl/bsc_datapath.sv
rtl/bankers_safety_check.sv
bench/tb.sv
